>>> hw/rtl/dcfq_pkg.sv
package dcfq_pkg;

  // Field and register widths
  localparam int MAG_W    = 16;  // Q8.8 magnification
  localparam int MAG_FRAC = 8;   // fraction bits of the magnification
  localparam int CNT_W    = 8;   // bad frame counter
  localparam int CFG_W    = 8;   // configuration data
  localparam int CFG_IDX_W = 1;  // configuration register index

  // Sequencer lengths
  localparam int STEP_W    = 4;
  localparam int MUL_STEPS = 11;
  localparam int CMP_STEPS = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_TOL = 1'b0,
    REG_MAX_BAD   = 1'b1
  } cfg_reg_t;

  // Operations of the shared multiplier
  typedef enum logic [3:0] {
    MUL_PWLO_M,   // wide width low bound times magnification
    MUL_PWHI_M,
    MUL_PHLO_M,
    MUL_PHHI_M,
    MUL_M2,       // magnification squared
    MUL_PA_LO,    // wide area low bound
    MUL_PA_HI,
    MUL_ZA_LO,    // zoom area low bound
    MUL_ZA_HI,
    MUL_PAM_LO,   // wide area low bound times magnification squared
    MUL_PAM_HI,
    MUL_NONE
  } mul_op_t;

  // Interval overlap checks
  typedef enum logic [1:0] {
    CMP_NONE,
    CMP_WIDTH,
    CMP_HEIGHT,
    CMP_AREA
  } cmp_op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;
    mul_op_t mul_op;
    cmp_op_t cmp_op;
    logic    update;
  } dcfq_cmd_t;

endpackage

>>> hw/rtl/dcfq_ctrl.sv
module dcfq_ctrl
  import dcfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output dcfq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_DONE
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   step;
  logic                out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Decode commands from state and step
  always_comb begin
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.mul_op = MUL_NONE;
    cmd.cmp_op = CMP_NONE;
    cmd.update = (state == S_DONE) && out_free;
    if (state == S_MUL) begin
      unique case (step)
        4'd0:    cmd.mul_op = MUL_PWLO_M;
        4'd1:    cmd.mul_op = MUL_PWHI_M;
        4'd2:    cmd.mul_op = MUL_PHLO_M;
        4'd3:    cmd.mul_op = MUL_PHHI_M;
        4'd4:    cmd.mul_op = MUL_M2;
        4'd5:    cmd.mul_op = MUL_PA_LO;
        4'd6:    cmd.mul_op = MUL_PA_HI;
        4'd7:    cmd.mul_op = MUL_ZA_LO;
        4'd8:    cmd.mul_op = MUL_ZA_HI;
        4'd9:    cmd.mul_op = MUL_PAM_LO;
        4'd10:   cmd.mul_op = MUL_PAM_HI;
        default: cmd.mul_op = MUL_NONE;
      endcase
    end
    if (state == S_CMP) begin
      unique case (step)
        4'd0:    cmd.cmp_op = CMP_WIDTH;
        4'd1:    cmd.cmp_op = CMP_HEIGHT;
        4'd2:    cmd.cmp_op = CMP_AREA;
        default: cmd.cmp_op = CMP_NONE;
      endcase
    end
  end

  // Sequence the item and hold the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
            step  <= '0;
          end
        end
        S_MUL: begin
          if (step == STEP_W'(MUL_STEPS - 1)) begin
            state <= S_CMP;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_CMP: begin
          if (step == STEP_W'(CMP_STEPS - 1)) begin
            state <= S_DONE;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_MUL && step == '0)
    else $error("accepted item did not start the multiply sequence");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("output valid rose outside the final step");

  a_update_free: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !(out_valid && out_stall))
    else $error("result overwrote a stalled output");

endmodule

>>> hw/rtl/dcfq_datapath.sv
module dcfq_datapath
  import dcfq_pkg::*;
#(
  parameter int DIM_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dcfq_cmd_t            cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 wide_found,
  input  logic [DIM_BITS-1:0]  wide_width,
  input  logic [DIM_BITS-1:0]  wide_height,
  input  logic                 zoom_found,
  input  logic [DIM_BITS-1:0]  zoom_width,
  input  logic [DIM_BITS-1:0]  zoom_height,
  input  logic [MAG_W-1:0]     zoom_mag,
  output logic                 wide_in_view,
  output logic                 zoom_in_view,
  output logic [CNT_W-1:0]     bad_count
);

  // Bound width, scaled bound width, multiplier operand and product widths
  localparam int LW = DIM_BITS + 2;
  localparam int SW = LW + MAG_W + 1;
  localparam int MW = ((2 * LW > 2 * MAG_W) ? 2 * LW : 2 * MAG_W) + 1;
  localparam int PW = 2 * MW;

  logic [CFG_W-1:0]        pixel_tolerance;
  logic [CNT_W-1:0]        max_bad_frames;
  logic [CNT_W-1:0]        bad_frames;

  logic                    wide_fnd;
  logic                    zoom_go;
  logic [MAG_W-1:0]        mag;
  logic signed [LW-1:0]    pwlo, pwhi, phlo, phhi;
  logic signed [LW-1:0]    zwlo, zwhi, zhlo, zhhi;
  logic signed [LW-1:0]    tol_ext;

  logic signed [SW-1:0]    pwm_lo, pwm_hi, phm_lo, phm_hi;
  logic [2*MAG_W-1:0]      m2;
  logic signed [2*LW-1:0]  pa_lo, pa_hi, za_lo, za_hi;
  logic signed [PW-1:0]    pam_lo, pam_hi;

  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    product;

  logic signed [PW-1:0]    cmp_zlo, cmp_zhi, cmp_plo, cmp_phi;
  logic                    overlap;
  logic                    wok, hok, aok;

  logic                    hit;
  logic [CNT_W:0]          bad_inc;
  logic [CNT_W-1:0]        bad_next;

  assign tol_ext = $signed({{(LW - CFG_W){1'b0}}, pixel_tolerance});

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_tolerance <= CFG_W'(5);
      max_bad_frames  <= CNT_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PIXEL_TOL: pixel_tolerance <= cfg_data;
        REG_MAX_BAD:   max_bad_frames  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Capture the item and widen its sizes by the tolerance
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wide_fnd <= wide_found;
      zoom_go  <= zoom_found && (zoom_mag != '0);
      mag      <= zoom_mag;
      pwlo     <= $signed({2'b00, wide_width})  - tol_ext;
      pwhi     <= $signed({2'b00, wide_width})  + tol_ext;
      phlo     <= $signed({2'b00, wide_height}) - tol_ext;
      phhi     <= $signed({2'b00, wide_height}) + tol_ext;
      zwlo     <= $signed({2'b00, zoom_width})  - tol_ext;
      zwhi     <= $signed({2'b00, zoom_width})  + tol_ext;
      zhlo     <= $signed({2'b00, zoom_height}) - tol_ext;
      zhhi     <= $signed({2'b00, zoom_height}) + tol_ext;
    end
  end

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_PWLO_M: mul_a = {{(MW - LW){pwlo[LW-1]}}, pwlo};
      MUL_PWHI_M: mul_a = {{(MW - LW){pwhi[LW-1]}}, pwhi};
      MUL_PHLO_M: mul_a = {{(MW - LW){phlo[LW-1]}}, phlo};
      MUL_PHHI_M: mul_a = {{(MW - LW){phhi[LW-1]}}, phhi};
      MUL_M2:     mul_a = {{(MW - MAG_W){1'b0}}, mag};
      MUL_PA_LO:  mul_a = {{(MW - LW){pwlo[LW-1]}}, pwlo};
      MUL_PA_HI:  mul_a = {{(MW - LW){pwhi[LW-1]}}, pwhi};
      MUL_ZA_LO:  mul_a = {{(MW - LW){zwlo[LW-1]}}, zwlo};
      MUL_ZA_HI:  mul_a = {{(MW - LW){zwhi[LW-1]}}, zwhi};
      MUL_PAM_LO: mul_a = {{(MW - 2 * LW){pa_lo[2*LW-1]}}, pa_lo};
      MUL_PAM_HI: mul_a = {{(MW - 2 * LW){pa_hi[2*LW-1]}}, pa_hi};
      default:    mul_a = '0;
    endcase
    case (cmd.mul_op) inside
      MUL_PWLO_M, MUL_PWHI_M, MUL_PHLO_M, MUL_PHHI_M, MUL_M2:
                  mul_b = {{(MW - MAG_W){1'b0}}, mag};
      MUL_PA_LO:  mul_b = {{(MW - LW){phlo[LW-1]}}, phlo};
      MUL_PA_HI:  mul_b = {{(MW - LW){phhi[LW-1]}}, phhi};
      MUL_ZA_LO:  mul_b = {{(MW - LW){zhlo[LW-1]}}, zhlo};
      MUL_ZA_HI:  mul_b = {{(MW - LW){zhhi[LW-1]}}, zhhi};
      MUL_PAM_LO, MUL_PAM_HI:
                  mul_b = {{(MW - 2 * MAG_W){1'b0}}, m2};
      default:    mul_b = '0;
    endcase
  end

  assign product = mul_a * mul_b;

  // Store each product in its own register
  always_ff @(posedge clk) begin
    case (cmd.mul_op)
      MUL_PWLO_M: pwm_lo <= product[SW-1:0];
      MUL_PWHI_M: pwm_hi <= product[SW-1:0];
      MUL_PHLO_M: phm_lo <= product[SW-1:0];
      MUL_PHHI_M: phm_hi <= product[SW-1:0];
      MUL_M2:     m2     <= product[2*MAG_W-1:0];
      MUL_PA_LO:  pa_lo  <= product[2*LW-1:0];
      MUL_PA_HI:  pa_hi  <= product[2*LW-1:0];
      MUL_ZA_LO:  za_lo  <= product[2*LW-1:0];
      MUL_ZA_HI:  za_hi  <= product[2*LW-1:0];
      MUL_PAM_LO: pam_lo <= product;
      MUL_PAM_HI: pam_hi <= product;
      default:    ;
    endcase
  end

  // Align zoom values to the wide side's scale and pick one interval pair
  always_comb begin
    cmp_zlo = '0;
    cmp_zhi = '0;
    cmp_plo = '0;
    cmp_phi = '0;
    case (cmd.cmp_op)
      CMP_WIDTH: begin
        cmp_zlo = {{(PW - LW - MAG_FRAC){zwlo[LW-1]}}, zwlo, {MAG_FRAC{1'b0}}};
        cmp_zhi = {{(PW - LW - MAG_FRAC){zwhi[LW-1]}}, zwhi, {MAG_FRAC{1'b0}}};
        cmp_plo = {{(PW - SW){pwm_lo[SW-1]}}, pwm_lo};
        cmp_phi = {{(PW - SW){pwm_hi[SW-1]}}, pwm_hi};
      end
      CMP_HEIGHT: begin
        cmp_zlo = {{(PW - LW - MAG_FRAC){zhlo[LW-1]}}, zhlo, {MAG_FRAC{1'b0}}};
        cmp_zhi = {{(PW - LW - MAG_FRAC){zhhi[LW-1]}}, zhhi, {MAG_FRAC{1'b0}}};
        cmp_plo = {{(PW - SW){phm_lo[SW-1]}}, phm_lo};
        cmp_phi = {{(PW - SW){phm_hi[SW-1]}}, phm_hi};
      end
      CMP_AREA: begin
        cmp_zlo = {{(PW - 2 * LW - 2 * MAG_FRAC){za_lo[2*LW-1]}}, za_lo,
                   {(2 * MAG_FRAC){1'b0}}};
        cmp_zhi = {{(PW - 2 * LW - 2 * MAG_FRAC){za_hi[2*LW-1]}}, za_hi,
                   {(2 * MAG_FRAC){1'b0}}};
        cmp_plo = pam_lo;
        cmp_phi = pam_hi;
      end
      default: ;
    endcase
  end

  assign overlap = (cmp_zlo <= cmp_phi && cmp_zlo >= cmp_plo) ||
                   (cmp_zhi <= cmp_phi && cmp_zhi >= cmp_plo) ||
                   (cmp_zlo <= cmp_plo && cmp_zhi >= cmp_phi);

  // Record each overlap flag
  always_ff @(posedge clk) begin
    case (cmd.cmp_op)
      CMP_WIDTH:  wok <= overlap;
      CMP_HEIGHT: hok <= overlap;
      CMP_AREA:   aok <= overlap;
      default:    ;
    endcase
  end

  // Count bad frames: decrement on a hit, increment and saturate at the limit on a miss
  assign hit     = zoom_go && wok && hok && aok;
  assign bad_inc = {1'b0, bad_frames} + 1'b1;

  always_comb begin
    if (hit) begin
      bad_next = (bad_frames != '0) ? bad_frames - 1'b1 : bad_frames;
    end else if (bad_inc >= {1'b0, max_bad_frames}) begin
      bad_next = max_bad_frames;
    end else begin
      bad_next = bad_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_frames <= '0;
    end else if (cmd.update) begin
      bad_frames <= bad_next;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      wide_in_view <= wide_fnd;
      zoom_in_view <= hit && (bad_next == '0);
      bad_count    <= bad_next;
    end
  end

  a_miss_clamps: assert property (@(posedge clk) disable iff (rst)
    cmd.update && !hit && !cfg_we |=> bad_frames <= max_bad_frames)
    else $error("bad frame count above its limit after a miss");

  a_hit_decrements: assert property (@(posedge clk) disable iff (rst)
    cmd.update && hit && bad_frames != '0 |=> bad_frames == $past(bad_frames) - 1'b1)
    else $error("hit did not decrement the bad frame count");

  a_view_zero: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.update) && zoom_in_view |-> bad_count == '0)
    else $error("zoom reported in view with a nonzero count");

endmodule

>>> hw/rtl/dual_camera_fixation_qualifier.sv
// Channel   Direction  Handshake              Payload
// in        in         in_valid / in_stall    wide_found, wide_width, wide_height,
//                                             zoom_found, zoom_width, zoom_height, zoom_mag
// out       out        out_valid / out_stall  wide_in_view, zoom_in_view, bad_count
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item is captured, then passes through eleven products on the single shared
// 33x33 signed multiplier, three interval overlap checks and a final step that
// updates the counter and loads the output register.
// The result sits in an output register; the next item is taken while it waits,
// and the final step holds until that register is free.
// Reset is synchronous on rst; it clears the counter and restores the registers.
module dual_camera_fixation_qualifier
  import dcfq_pkg::*;
#(
  parameter int DIM_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 wide_found,
  input  logic [DIM_BITS-1:0]  wide_width,
  input  logic [DIM_BITS-1:0]  wide_height,
  input  logic                 zoom_found,
  input  logic [DIM_BITS-1:0]  zoom_width,
  input  logic [DIM_BITS-1:0]  zoom_height,
  input  logic [MAG_W-1:0]     zoom_mag,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 wide_in_view,
  output logic                 zoom_in_view,
  output logic [CNT_W-1:0]     bad_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dcfq_cmd_t cmd;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  dcfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  dcfq_datapath #(
    .DIM_BITS (DIM_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .wide_found   (wide_found),
    .wide_width   (wide_width),
    .wide_height  (wide_height),
    .zoom_found   (zoom_found),
    .zoom_width   (zoom_width),
    .zoom_height  (zoom_height),
    .zoom_mag     (zoom_mag),
    .wide_in_view (wide_in_view),
    .zoom_in_view (zoom_in_view),
    .bad_count    (bad_count)
  );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import dcfq_pkg::*;
();

  localparam int DIM_BITS     = 10;
  localparam int DIM_MAX      = (1 << DIM_BITS) - 1;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int IDLE_PCT     = 37;
  localparam int LONG_HOLD    = 300;

  typedef struct packed {
    logic                wide_found;
    logic [DIM_BITS-1:0] wide_width;
    logic [DIM_BITS-1:0] wide_height;
    logic                zoom_found;
    logic [DIM_BITS-1:0] zoom_width;
    logic [DIM_BITS-1:0] zoom_height;
    logic [MAG_W-1:0]    zoom_mag;
  } frame_t;

  typedef struct packed {
    logic             wide_in_view;
    logic             zoom_in_view;
    logic [CNT_W-1:0] bad_count;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 wide_found = 1'b0;
  logic [DIM_BITS-1:0]  wide_width = '0;
  logic [DIM_BITS-1:0]  wide_height = '0;
  logic                 zoom_found = 1'b0;
  logic [DIM_BITS-1:0]  zoom_width = '0;
  logic [DIM_BITS-1:0]  zoom_height = '0;
  logic [MAG_W-1:0]     zoom_mag = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 wide_in_view;
  logic                 zoom_in_view;
  logic [CNT_W-1:0]     bad_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Frames waiting to be sent and verdicts waiting to come out
  frame_t   frames_pending[$];
  verdict_t verdicts_due[$];

  // Shadow of the qualifier's registers and counter
  logic [CFG_W-1:0] tol_model = 8'd5;
  logic [CFG_W-1:0] max_model = 8'd10;
  int               bad_frames_model = 0;

  int frames_sent = 0;
  int results_seen = 0;
  int on_target_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycles = 0;

  dual_camera_fixation_qualifier #(.DIM_BITS(DIM_BITS)) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .wide_found  (wide_found),
    .wide_width  (wide_width),
    .wide_height (wide_height),
    .zoom_found  (zoom_found),
    .zoom_width  (zoom_width),
    .zoom_height (zoom_height),
    .zoom_mag    (zoom_mag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .wide_in_view(wide_in_view),
    .zoom_in_view(zoom_in_view),
    .bad_count   (bad_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Closed intervals, both already scaled to a common denominator
  function automatic logic spans_meet(longint zlo, longint zhi, longint plo, longint phi);
    return (zlo <= phi && zlo >= plo) || (zhi <= phi && zhi >= plo) ||
           (zlo <= plo && zhi >= phi);
  endfunction

  // Qualify one frame and advance the bad frame counter
  function automatic verdict_t judge_frame(frame_t f);
    verdict_t v;
    longint t, m, m2;
    longint pwlo, pwhi, phlo, phhi, zwlo, zwhi, zhlo, zhhi;
    logic hit;
    int nxt;
    t = longint'(tol_model);
    m = longint'(f.zoom_mag);
    hit = 1'b0;
    if (f.zoom_found && m != 0) begin
      m2 = m * m;
      pwlo = longint'(f.wide_width) - t;
      pwhi = longint'(f.wide_width) + t;
      phlo = longint'(f.wide_height) - t;
      phhi = longint'(f.wide_height) + t;
      zwlo = longint'(f.zoom_width) - t;
      zwhi = longint'(f.zoom_width) + t;
      zhlo = longint'(f.zoom_height) - t;
      zhhi = longint'(f.zoom_height) + t;
      // zoom sizes carry m/256, so zoom sizes are scaled by 256 and wide sizes by m
      hit = spans_meet(zwlo * 256, zwhi * 256, pwlo * m, pwhi * m) &&
            spans_meet(zhlo * 256, zhhi * 256, phlo * m, phhi * m) &&
            spans_meet(zwlo * zhlo * 65536, zwhi * zhhi * 65536,
                       pwlo * phlo * m2, pwhi * phhi * m2);
    end
    v.wide_in_view = f.wide_found;
    if (hit) begin
      if (bad_frames_model > 0) bad_frames_model--;
      v.zoom_in_view = (bad_frames_model == 0);
    end else begin
      nxt = bad_frames_model + 1;
      if (nxt >= int'(max_model)) nxt = int'(max_model);
      bad_frames_model = nxt;
      v.zoom_in_view = 1'b0;
    end
    v.bad_count = CNT_W'(bad_frames_model);
    return v;
  endfunction

  function automatic frame_t mk(bit wf, int ww, int wh, bit zf, int zw, int zh, int mag);
    frame_t f;
    f.wide_found = wf;
    f.wide_width = DIM_BITS'(ww);
    f.wide_height = DIM_BITS'(wh);
    f.zoom_found = zf;
    f.zoom_width = DIM_BITS'(zw);
    f.zoom_height = DIM_BITS'(zh);
    f.zoom_mag = MAG_W'(mag);
    return f;
  endfunction

  // Frame with every field drawn at random
  function automatic frame_t noise_frame();
    return mk(bit'($urandom_range(1)), $urandom, $urandom, bit'($urandom_range(1)),
              $urandom, $urandom, $urandom);
  endfunction

  // Zoom size that a wide size maps to, give or take a couple of pixels
  function automatic logic [DIM_BITS-1:0] scaled_dim(int unsigned p, logic [MAG_W-1:0] mag);
    int z;
    z = int'((p * mag) / 256) + int'($urandom_range(4)) - 2;
    if (z < 0) z = 0;
    if (z > DIM_MAX) z = DIM_MAX;
    return DIM_BITS'(z);
  endfunction

  // Frame whose two cameras look at the same object
  function automatic frame_t matched_frame();
    frame_t f;
    int unsigned cap;
    f.zoom_mag = ($urandom_range(4) == 0) ? MAG_W'($urandom_range(1, 65535))
                                          : MAG_W'($urandom_range(256, 4096));
    cap = (DIM_MAX * 256) / f.zoom_mag;
    if (cap > DIM_MAX) cap = DIM_MAX;
    if (cap < 1) cap = 1;
    f.wide_width = DIM_BITS'($urandom_range(1, cap));
    f.wide_height = DIM_BITS'($urandom_range(1, cap));
    f.zoom_width = scaled_dim(f.wide_width, f.zoom_mag);
    f.zoom_height = scaled_dim(f.wide_height, f.zoom_mag);
    f.wide_found = ($urandom_range(9) != 0);
    f.zoom_found = ($urandom_range(19) != 0);
    return f;
  endfunction

  // Queue runs of matched frames and runs of unrelated noise
  task automatic queue_frames(int n);
    int k, run_len, kind;
    k = 0;
    while (k < n) begin
      run_len = $urandom_range(1, 12);
      kind = $urandom_range(99);
      for (int j = 0; j < run_len && k < n; j++) begin
        frames_pending.push_back(kind < 70 ? matched_frame() : noise_frame());
        k++;
      end
    end
  endtask

  // Wait until every verdict is in and the block has settled
  task automatic drain();
    do @(posedge clk); while (frames_pending.size() != 0 || verdicts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PIXEL_TOL) tol_model = val;
    else max_model = val;
  endtask

  // Driver: hold a stalled item, otherwise offer the next frame or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        verdicts_due.push_back(judge_frame(frames_pending.pop_front()));
        frames_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (frames_pending.size() != 0 &&
            ((frames_sent >= 300 && frames_sent < 420) || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          wide_found <= frames_pending[0].wide_found;
          wide_width <= frames_pending[0].wide_width;
          wide_height <= frames_pending[0].wide_height;
          zoom_found <= frames_pending[0].zoom_found;
          zoom_width <= frames_pending[0].zoom_width;
          zoom_height <= frames_pending[0].zoom_height;
          zoom_mag <= frames_pending[0].zoom_mag;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Hold the output off for one long stretch once enough results are in
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen >= 150 && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end
  end

  // Monitor: check each item against the oldest verdict, then pick the stall
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected item: wide=%0b zoom=%0b count=%0d",
                     wide_in_view, zoom_in_view, bad_count);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (wide_in_view !== want.wide_in_view || zoom_in_view !== want.zoom_in_view ||
              bad_count !== want.bad_count) begin
            if (mismatches < 10)
              $display("item %0d: expected %0b/%0b/%0d, got %0b/%0b/%0d",
                       results_seen, want.wide_in_view, want.zoom_in_view, want.bad_count,
                       wide_in_view, zoom_in_view, bad_count);
            mismatches++;
          end
        end
        if (zoom_in_view === 1'b1) on_target_seen++;
        results_seen++;
      end
      out_stall <= (hold_left > 0) ||
                   ((results_seen < 300 || results_seen >= 420) &&
                    ($urandom_range(99) < IDLE_PCT));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, verdicts_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed frames at the default registers
    frames_pending.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    frames_pending.push_back(mk(1, DIM_MAX, DIM_MAX, 1, DIM_MAX, DIM_MAX, 65535));
    frames_pending.push_back(mk(1, 100, 80, 1, 100, 80, 0));
    frames_pending.push_back(mk(1, 100, 80, 0, 100, 80, 256));
    frames_pending.push_back(mk(0, 0, 0, 1, 0, 0, 1));
    frames_pending.push_back(mk(1, DIM_MAX, 0, 1, 0, DIM_MAX, 256));
    frames_pending.push_back(mk(1, 3, 2, 1, 3, 2, 256));
    frames_pending.push_back(mk(1, 4, DIM_MAX, 1, DIM_MAX, DIM_MAX, 65535));
    // run of hits to bring the counter back to zero
    repeat (8) frames_pending.push_back(mk(1, 200, 150, 1, 400, 300, 512));
    frames_pending.push_back(mk(1, DIM_MAX, DIM_MAX, 1, DIM_MAX, DIM_MAX, 256));
    frames_pending.push_back(mk(0, 512, 511, 1, 256, 255, 128));
    frames_pending.push_back(mk(1, 341, 341, 1, DIM_MAX, DIM_MAX, 768));
    frames_pending.push_back(mk(1, 682, 341, 1, 682, 341, 256));
    frames_pending.push_back(mk(1, 1, 1, 1, 1, 1, 65535));
    frames_pending.push_back(mk(1, 1, 1, 1, 1, 1, 32768));
    queue_frames(180);
    drain();

    // Tightest settings
    write_reg(REG_PIXEL_TOL, 8'd0);
    write_reg(REG_MAX_BAD, 8'd1);
    queue_frames(120);
    drain();

    // Widest settings, then a burst of misses to push the counter up
    write_reg(REG_PIXEL_TOL, 8'd255);
    write_reg(REG_MAX_BAD, 8'd255);
    queue_frames(150);
    repeat (40) frames_pending.push_back(mk(1, $urandom, $urandom, 0, $urandom, $urandom,
                                            $urandom_range(1, 65535)));
    drain();

    // Drop the limit below the current count
    write_reg(REG_MAX_BAD, 8'd3);
    queue_frames(60);
    drain();

    // Zero limit
    write_reg(REG_PIXEL_TOL, 8'd17);
    write_reg(REG_MAX_BAD, 8'd0);
    queue_frames(80);
    drain();

    // Back to the defaults
    write_reg(REG_PIXEL_TOL, 8'd5);
    write_reg(REG_MAX_BAD, 8'd10);
    queue_frames(100);
    drain();

    $display("sent %0d frames over six register settings, checked %0d verdicts",
             frames_sent, results_seen);
    $display("zoom camera qualified on %0d frames, %0d mismatches", on_target_seen, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
